// ----- rtl/array_priority_queue_defines.svh -----
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define APQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apq_pkg.sv -----
package apq_pkg;

	localparam int DEPTH_DEF     = 8;
	localparam int PRIO_BITS_DEF = 16;

	localparam int FUNC_W      = 2;
	localparam int ELEM_W      = 32;
	localparam int PRIO_IN_W   = 16;
	localparam int STATUS_W    = 2;
	localparam int HELD_W      = 4;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- rtl/apq_cell.sv -----
module apq_cell #(
	parameter int IDX       = 0,
	parameter int DEPTH     = apq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = apq_pkg::PRIO_BITS_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1),
	parameter int IDX_W     = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  apq_pkg::cell_ctrl_t        ctrl,
	input  logic [CNT_W-1:0]           count,
	input  logic [IDX_W-1:0]           del_idx,
	input  logic [apq_pkg::ELEM_W-1:0] ins_elem,
	input  logic [PRIO_BITS-1:0]       ins_prio,
	input  logic [apq_pkg::ELEM_W-1:0] nxt_elem,
	input  logic [PRIO_BITS-1:0]       nxt_prio,
	input  logic [apq_pkg::ELEM_W-1:0] cand_elem_in,
	input  logic [PRIO_BITS-1:0]       cand_prio_in,
	input  logic [IDX_W-1:0]           cand_idx_in,
	output logic [apq_pkg::ELEM_W-1:0] elem,
	output logic [PRIO_BITS-1:0]       prio,
	output logic [apq_pkg::ELEM_W-1:0] cand_elem_out,
	output logic [PRIO_BITS-1:0]       cand_prio_out,
	output logic [IDX_W-1:0]           cand_idx_out
);

	logic [apq_pkg::ELEM_W-1:0] elem_q;
	logic [PRIO_BITS-1:0]       prio_q;
	logic [apq_pkg::ELEM_W-1:0] cand_elem_q;
	logic [PRIO_BITS-1:0]       cand_prio_q;
	logic [IDX_W-1:0]           cand_idx_q;
	logic                       held;
	logic                       take_own;
	logic                       load_ins;
	logic                       load_nxt;

	assign held     = CNT_W'(IDX) < count;
	assign take_own = (IDX == 0) || (held && (prio_q > cand_prio_in));
	assign load_ins = ctrl.ins && (CNT_W'(IDX) == count);
	assign load_nxt = ctrl.shift && (IDX_W'(IDX) >= del_idx) && (CNT_W'(IDX + 1) < count);

	// entry slot
	always_ff @(posedge clk) begin
		if (load_ins) begin
			elem_q <= ins_elem;
			prio_q <= ins_prio;
		end else if (load_nxt) begin
			elem_q <= nxt_elem;
			prio_q <= nxt_prio;
		end
	end

	// running best, handed one cell down every cycle
	always_ff @(posedge clk) begin
		if (take_own) begin
			cand_elem_q <= elem_q;
			cand_prio_q <= prio_q;
			cand_idx_q  <= IDX_W'(IDX);
		end else begin
			cand_elem_q <= cand_elem_in;
			cand_prio_q <= cand_prio_in;
			cand_idx_q  <= cand_idx_in;
		end
	end

	assign elem          = elem_q;
	assign prio          = prio_q;
	assign cand_elem_out = cand_elem_q;
	assign cand_prio_out = cand_prio_q;
	assign cand_idx_out  = cand_idx_q;

endmodule

// ----- rtl/array_priority_queue.sv -----
// array_priority_queue: fixed-depth priority queue of element/priority pairs
// kept in insertion order, one entry per cell of a chain.
// s_* channel takes one command word: insert, peek highest or delete highest.
// m_* channel returns one result word per command: status, removed element,
// top priority and the number of entries held afterward.
// Insert and no-op commands, and peek or delete on an empty queue, go
// straight to the done state. Peek and delete on a non-empty queue first
// pass a scan state: the best candidate walks down the cell chain one cell
// per cycle, so the chain length sets the scan time. A delete closes the gap
// as each later cell loads from its neighbor, while the result is loaded.
// One command is in flight at a time; the next is accepted the cycle after
// its result is loaded, even if that result still waits in the output register.
// If m_tready stays low, the result holds and the block holds in its final
// state until the output register frees.
// Reset empties the queue and drops any pending result; slot contents are
// left as they are and are never read until written again.
`include "array_priority_queue_defines.svh"

module array_priority_queue #(
	parameter int DEPTH     = apq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = apq_pkg::PRIO_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// func[1:0], elem_value[33:2], prio_in[49:34], zero[55:50]
	input  logic [apq_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], out_elem[33:2], out_prio[49:34], entries_held[53:50], zero[55:54]
	output logic [apq_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int EW     = apq_pkg::ELEM_W;
	localparam int PIW    = apq_pkg::PRIO_IN_W;
	localparam int FW     = apq_pkg::FUNC_W;
	localparam int SW     = apq_pkg::STATUS_W;
	localparam int HW     = apq_pkg::HELD_W;
	localparam int OUT_PAD = apq_pkg::OUT_TDATA_W - SW - EW - PIW - HW;

	apq_pkg::state_t     state_q, state_nxt;
	apq_pkg::cell_ctrl_t ctrl;

	logic [CNT_W-1:0]     count_q, count_nxt;
	logic [IDX_W-1:0]     scan_cnt_q;
	logic [FW-1:0]        func_q;
	logic [EW-1:0]        elem_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 m_tvalid_q;
	logic [SW-1:0]        status_q;
	logic [EW-1:0]        out_elem_q;
	logic [PIW-1:0]       out_prio_q;
	logic [HW-1:0]        held_q;

	logic                 commit;
	logic                 accept;
	logic [FW-1:0]        in_func;
	logic [EW-1:0]        in_elem;
	logic [PIW-1:0]       in_prio;
	logic [PRIO_BITS-1:0] in_prio_w;
	logic [SW-1:0]        res_status;
	logic [EW-1:0]        res_elem;
	logic [PRIO_BITS-1:0] res_prio;
	logic [PIW-1:0]       res_prio_o;
	logic [HW-1:0]        res_held;

	logic [EW-1:0]        ent_elem  [DEPTH+1];
	logic [PRIO_BITS-1:0] ent_prio  [DEPTH+1];
	logic [EW-1:0]        cand_elem [DEPTH+1];
	logic [PRIO_BITS-1:0] cand_prio [DEPTH+1];
	logic [IDX_W-1:0]     cand_idx  [DEPTH+1];

	assign in_func = s_tdata[FW-1:0];
	assign in_elem = s_tdata[FW+EW-1:FW];
	assign in_prio = s_tdata[FW+EW+PIW-1:FW+EW];
	assign accept  = s_tvalid && s_tready;

	generate
		if (PRIO_BITS <= PIW) begin : g_prio_narrow
			assign in_prio_w  = in_prio[PRIO_BITS-1:0];
			assign res_prio_o = PIW'(res_prio);
		end else begin : g_prio_wide
			assign in_prio_w  = {{(PRIO_BITS-PIW){1'b0}}, in_prio};
			assign res_prio_o = res_prio[PIW-1:0];
		end
		if (CNT_W >= HW) begin : g_held_slice
			assign res_held = count_nxt[HW-1:0];
		end else begin : g_held_ext
			assign res_held = {{(HW-CNT_W){1'b0}}, count_nxt};
		end
	endgenerate

	// cell chain
	assign ent_elem[DEPTH]  = '0;
	assign ent_prio[DEPTH]  = '0;
	assign cand_elem[0]     = '0;
	assign cand_prio[0]     = '0;
	assign cand_idx[0]      = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		apq_cell #(
			.IDX       (i),
			.DEPTH     (DEPTH),
			.PRIO_BITS (PRIO_BITS),
			.CNT_W     (CNT_W),
			.IDX_W     (IDX_W)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.count         (count_q),
			.del_idx       (cand_idx[DEPTH]),
			.ins_elem      (elem_q),
			.ins_prio      (prio_q),
			.nxt_elem      (ent_elem[i+1]),
			.nxt_prio      (ent_prio[i+1]),
			.cand_elem_in  (cand_elem[i]),
			.cand_prio_in  (cand_prio[i]),
			.cand_idx_in   (cand_idx[i]),
			.elem          (ent_elem[i]),
			.prio          (ent_prio[i]),
			.cand_elem_out (cand_elem[i+1]),
			.cand_prio_out (cand_prio[i+1]),
			.cand_idx_out  (cand_idx[i+1])
		);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			apq_pkg::ST_IDLE: begin
				if (accept) begin
					if (((in_func == apq_pkg::FN_PEEK) || (in_func == apq_pkg::FN_DELETE))
							&& (count_q != '0)) begin
						state_nxt = apq_pkg::ST_SCAN;
					end else begin
						state_nxt = apq_pkg::ST_DONE;
					end
				end
			end
			apq_pkg::ST_SCAN: begin
				if (scan_cnt_q == IDX_W'(DEPTH - 1)) begin
					state_nxt = apq_pkg::ST_DONE;
				end
			end
			apq_pkg::ST_DONE: begin
				if (commit) begin
					state_nxt = apq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = apq_pkg::ST_IDLE;
		endcase
	end

	// outputs and result
	always_comb begin
		s_tready   = (state_q == apq_pkg::ST_IDLE);
		commit     = (state_q == apq_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
		res_status = apq_pkg::STAT_DONE;
		res_elem   = '0;
		res_prio   = '0;
		count_nxt  = count_q;
		ctrl.ins   = 1'b0;
		ctrl.shift = 1'b0;
		unique case (func_q) inside
			apq_pkg::FN_INSERT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					res_status = apq_pkg::STAT_FULL;
				end else begin
					ctrl.ins  = commit;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			apq_pkg::FN_PEEK, apq_pkg::FN_DELETE: begin
				if (count_q == '0) begin
					res_status = apq_pkg::STAT_EMPTY;
				end else begin
					res_prio = cand_prio[DEPTH];
					if (func_q == apq_pkg::FN_DELETE) begin
						res_elem   = cand_elem[DEPTH];
						ctrl.shift = commit;
						count_nxt  = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= apq_pkg::ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (commit) begin
				count_q <= count_nxt;
			end
			if (state_q == apq_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// command and result words
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_func;
			elem_q <= in_elem;
			prio_q <= in_prio_w;
		end
		if (commit) begin
			status_q   <= res_status;
			out_elem_q <= res_elem;
			out_prio_q <= res_prio_o;
			held_q     <= res_held;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, held_q, out_prio_q, out_elem_q, status_q};

	`APQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`APQ_ASSERT_NEXT(a_commit_valid, commit, m_tvalid_q, "result not presented after commit")
	`APQ_ASSERT_NEXT(a_scan_entry,
		accept && (in_func == apq_pkg::FN_DELETE) && (count_q != '0),
		(state_q == apq_pkg::ST_SCAN) && (scan_cnt_q == '0),
		"delete on non-empty queue skipped scan")
	`APQ_ASSERT_NEXT(a_delete_count,
		commit && (func_q == apq_pkg::FN_DELETE) && (count_q != '0),
		count_q == $past(count_q) - CNT_W'(1),
		"delete did not shrink count")

endmodule

// ----- tb/apq_checker.sv -----
`timescale 1ns / 1ps

module apq_checker #(
	parameter int DEPTH     = apq_pkg::DEPTH_DEF,
	parameter int PRIO_BITS = apq_pkg::PRIO_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// func[1:0], elem_value[33:2], prio_in[49:34], zero[55:50]
	input  logic [apq_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], out_elem[33:2], out_prio[49:34], entries_held[53:50], zero[55:54]
	input  logic [apq_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              errors,
	output int                              waiting,
	output int                              removed,
	output int                              full_hits,
	output int                              empty_hits
);

	localparam logic [apq_pkg::PRIO_IN_W-1:0] PRIO_MASK =
		apq_pkg::PRIO_IN_W'((64'd1 << PRIO_BITS) - 64'd1);

	typedef struct packed {
		logic [apq_pkg::STATUS_W-1:0]  status;
		logic [apq_pkg::ELEM_W-1:0]    elem;
		logic [apq_pkg::PRIO_IN_W-1:0] prio;
		logic [apq_pkg::HELD_W-1:0]    held;
	} pq_result_t;

	logic [apq_pkg::ELEM_W-1:0]    slot_elem [DEPTH];
	logic [apq_pkg::PRIO_IN_W-1:0] slot_prio [DEPTH];
	int                            held_count;
	pq_result_t                    pending_results [$];

	function automatic pq_result_t apply_command(
		input logic [apq_pkg::FUNC_W-1:0]    opcode,
		input logic [apq_pkg::ELEM_W-1:0]    elem,
		input logic [apq_pkg::PRIO_IN_W-1:0] prio
	);
		pq_result_t r;
		int top;
		r = '0;
		case (opcode)
			apq_pkg::FN_INSERT: begin
				if (held_count >= DEPTH) begin
					r.status = apq_pkg::STAT_FULL;
					full_hits++;
				end else begin
					slot_elem[held_count] = elem;
					slot_prio[held_count] = prio & PRIO_MASK;
					held_count++;
				end
			end
			apq_pkg::FN_PEEK, apq_pkg::FN_DELETE: begin
				if (held_count == 0) begin
					r.status = apq_pkg::STAT_EMPTY;
					empty_hits++;
				end else begin
					// earliest entry wins a tie
					top = 0;
					for (int i = 1; i < held_count; i++)
						if (slot_prio[i] > slot_prio[top])
							top = i;
					r.prio = slot_prio[top];
					if (opcode == apq_pkg::FN_DELETE) begin
						r.elem = slot_elem[top];
						for (int j = top; j + 1 < held_count; j++) begin
							slot_elem[j] = slot_elem[j + 1];
							slot_prio[j] = slot_prio[j + 1];
						end
						held_count--;
						removed++;
					end
				end
			end
			default: ;
		endcase
		r.held = apq_pkg::HELD_W'(held_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pq_result_t got;
		pq_result_t want;
		if (!arst_n) begin
			held_count = 0;
			pending_results.delete();
			waiting = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_command(s_tdata[1:0], s_tdata[33:2],
					s_tdata[49:34]));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[33:2], m_tdata[49:34], m_tdata[53:50]};
				if (pending_results.size() == 0) begin
					errors++;
					$error("result word with no command outstanding: %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status) begin
						errors++;
						$error("status: expected %0d, got %0d", want.status, got.status);
					end
					if (got.elem !== want.elem) begin
						errors++;
						$error("out_elem: expected %0d, got %0d", $signed(want.elem),
							$signed(got.elem));
					end
					if (got.prio !== want.prio) begin
						errors++;
						$error("out_prio: expected %0d, got %0d", want.prio, got.prio);
					end
					if (got.held !== want.held) begin
						errors++;
						$error("entries_held: expected %0d, got %0d", want.held, got.held);
					end
				end
			end
			waiting = pending_results.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH      = apq_pkg::DEPTH_DEF;
	localparam int RAND_WORDS = 1000;
	localparam int LIMIT      = 300000;
	localparam int HOLD_OFF   = 200;

	// unused opcode, block treats it as a no-op
	localparam logic [apq_pkg::FUNC_W-1:0] FN_NOP = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [apq_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [apq_pkg::OUT_TDATA_W-1:0] m_tdata;

	int errors;
	int waiting;
	int removed;
	int full_hits;
	int empty_hits;
	int words_sent = 0;
	int cycles = 0;
	bit calm = 1'b0;

	array_priority_queue #(
		.DEPTH     (DEPTH),
		.PRIO_BITS (apq_pkg::PRIO_BITS_DEF)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	apq_checker #(
		.DEPTH     (DEPTH),
		.PRIO_BITS (apq_pkg::PRIO_BITS_DEF)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.waiting    (waiting),
		.removed    (removed),
		.full_hits  (full_hits),
		.empty_hits (empty_hits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls, one long hold-off, no stalls while calm
	initial begin
		@(posedge arst_n);
		while (words_sent < 40) begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= 32);
		end
		@(posedge clk);
		m_tready <= 1'b0;
		repeat (HOLD_OFF) @(posedge clk);
		forever begin
			@(posedge clk);
			m_tready <= calm || ($urandom_range(99) >= 32);
		end
	end

	task automatic send_cmd(
		input logic [apq_pkg::FUNC_W-1:0]    opcode,
		input logic [apq_pkg::ELEM_W-1:0]    elem,
		input logic [apq_pkg::PRIO_IN_W-1:0] prio
	);
		if (!calm && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, prio, elem, opcode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	initial begin
		int bias;
		int pick;
		int ins_pct;
		int kind;
		logic [apq_pkg::FUNC_W-1:0]    opcode;
		logic [apq_pkg::ELEM_W-1:0]    elem;
		logic [apq_pkg::PRIO_IN_W-1:0] prio;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue
		send_cmd(apq_pkg::FN_PEEK,   32'h0000_0000, 16'h0000);
		send_cmd(apq_pkg::FN_DELETE, 32'hffff_ffff, 16'hffff);
		send_cmd(FN_NOP,             32'h0000_0000, 16'h0000);
		// fill to the brim with extremes and ties on the top priority
		send_cmd(apq_pkg::FN_INSERT, 32'h8000_0000, 16'h0000);
		send_cmd(apq_pkg::FN_INSERT, 32'h7fff_ffff, 16'hffff);
		send_cmd(apq_pkg::FN_INSERT, 32'hffff_ffff, 16'hffff);
		send_cmd(apq_pkg::FN_INSERT, 32'h0000_0000, 16'h0001);
		send_cmd(apq_pkg::FN_INSERT, 32'h0000_007b, 16'hffff);
		send_cmd(apq_pkg::FN_INSERT, 32'h5555_5555, 16'h8000);
		send_cmd(apq_pkg::FN_INSERT, 32'haaaa_aaaa, 16'h7fff);
		send_cmd(apq_pkg::FN_INSERT, 32'h0000_0001, 16'h0000);
		send_cmd(apq_pkg::FN_INSERT, 32'h7fff_ffff, 16'hffff);
		send_cmd(apq_pkg::FN_PEEK,   32'hdead_beef, 16'h1234);
		send_cmd(FN_NOP,             32'hffff_ffff, 16'hffff);
		// drain it
		repeat (DEPTH) send_cmd(apq_pkg::FN_DELETE, 32'h0000_0000, 16'h0000);
		send_cmd(apq_pkg::FN_DELETE, 32'h0000_0000, 16'h0000);
		send_cmd(apq_pkg::FN_PEEK,   32'h0000_0000, 16'h0000);

		bias = 0;
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n % 100 == 0)
				bias = $urandom_range(0, 2);
			calm = (n >= 400 && n < 600);
			ins_pct = (bias == 1) ? 70 : (bias == 2) ? 25 : 45;
			pick = $urandom_range(99);
			if (pick < 3)
				opcode = FN_NOP;
			else if (pick < ins_pct)
				opcode = apq_pkg::FN_INSERT;
			else if (pick < ins_pct + (100 - ins_pct) / 3)
				opcode = apq_pkg::FN_PEEK;
			else
				opcode = apq_pkg::FN_DELETE;
			elem = $urandom;
			kind = $urandom_range(9);
			if (kind < 5)
				prio = apq_pkg::PRIO_IN_W'($urandom_range(0, 7));
			else if (kind == 5)
				prio = $urandom_range(1) ? 16'hffff : 16'h0000;
			else
				prio = apq_pkg::PRIO_IN_W'($urandom_range(0, 65535));
			send_cmd(opcode, elem, prio);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);

		$display("%0d command words, %0d removals, %0d inserts refused as full",
			words_sent, removed, full_hits);
		$display("%0d peeks or deletes on an empty queue", empty_hits);
		if (errors == 0 && waiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
